FILE: src/skt_pkg.sv
// shared types and constants of the sorted key table
// no dependencies; used by skt_cell, skt_ctrl and the top level
`default_nettype none

package skt_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int KEY_W            = 16;
   localparam int PAYLOAD_W        = 48;
   localparam int COUNT_OUT_W      = 7;
   localparam int STATUS_W         = 2;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_INSERT,
      FSM_SEARCH,
      FSM_HOLD
   } fsm_state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                 ins_en;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: src/skt_cell.sv
// one table slot: holds a key and payload, compares against the broadcast key
// depends on skt_pkg
`default_nettype none

module skt_cell (
   input  wire logic                            clock,
   input  wire skt_pkg::cell_ctrl_type          cell_ctrl,
   input  wire logic                            valid,
   input  wire logic                            prev_gt,
   input  wire logic [skt_pkg::KEY_W-1:0]       prev_key,
   input  wire logic [skt_pkg::PAYLOAD_W-1:0]   prev_payload,
   input  wire logic                            sel,
   output      logic [skt_pkg::KEY_W-1:0]       key,
   output      logic [skt_pkg::PAYLOAD_W-1:0]   payload,
   output      logic                            gt,
   output      logic                            lt,
   output      logic [skt_pkg::PAYLOAD_W-1:0]   sel_payload
);

   logic [skt_pkg::KEY_W-1:0]     key_ff;
   logic [skt_pkg::KEY_W-1:0]     key_in;
   logic [skt_pkg::PAYLOAD_W-1:0] payload_ff;
   logic [skt_pkg::PAYLOAD_W-1:0] payload_in;

   assign gt = valid && (key_ff > cell_ctrl.key);
   assign lt = key_ff < cell_ctrl.key;

   // shift in from the neighbor, take the new entry, or keep
   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (cell_ctrl.ins_en) begin
         if (prev_gt) begin
            key_in     = prev_key;
            payload_in = prev_payload;
         end else if (gt || !valid) begin
            key_in     = cell_ctrl.key;
            payload_in = cell_ctrl.payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key         = key_ff;
   assign payload     = payload_ff;
   assign sel_payload = sel ? payload_ff : '0;

endmodule

`default_nettype wire

FILE: src/skt_ctrl.sv
// sequencer: handshakes, entry count, binary search steps, result register
// depends on skt_pkg
`default_nettype none

module skt_ctrl #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT,
   parameter int CNT_W    = $clog2(CAPACITY + 1),
   parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic                              req_operation,
   input  wire logic [skt_pkg::KEY_W-1:0]         req_key,
   input  wire logic [skt_pkg::PAYLOAD_W-1:0]     req_payload,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [skt_pkg::STATUS_W-1:0]      rsp_status,
   output      logic [skt_pkg::PAYLOAD_W-1:0]     rsp_found_payload,
   output      logic [skt_pkg::COUNT_OUT_W-1:0]   rsp_entry_count,
   input  wire logic [CAPACITY-1:0]               lt_vec,
   input  wire logic [CAPACITY-1:0]               gt_vec,
   input  wire logic [skt_pkg::PAYLOAD_W-1:0]     hit_payload,
   output      skt_pkg::cell_ctrl_type            cell_ctrl,
   output      logic [CNT_W-1:0]                  count,
   output      logic                              sel_en,
   output      logic [IDX_W-1:0]                  sel_idx
);

   skt_pkg::fsm_state_type state_ff, state_in;

   logic [CNT_W-1:0]                count_ff, count_in;
   logic [CNT_W-1:0]                lo_ff, lo_in;
   logic [CNT_W-1:0]                hi_ff, hi_in;
   logic                            job_op_ff, job_op_in;
   logic [skt_pkg::KEY_W-1:0]       job_key_ff, job_key_in;
   logic [skt_pkg::PAYLOAD_W-1:0]   job_payload_ff, job_payload_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [skt_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [skt_pkg::PAYLOAD_W-1:0]   rsp_payload_ff, rsp_payload_in;
   logic [skt_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [skt_pkg::STATUS_W-1:0]    hold_status_ff, hold_status_in;
   logic [skt_pkg::PAYLOAD_W-1:0]   hold_payload_ff, hold_payload_in;

   logic                            req_xfer;
   logic                            out_free;
   logic                            full;
   logic [CNT_W:0]                  mid_sum;
   logic [CNT_W-1:0]                mid;
   logic [IDX_W-1:0]                mid_idx;
   logic                            range_open;
   logic                            step_lt;
   logic                            step_gt;
   logic                            fin;
   logic [skt_pkg::STATUS_W-1:0]    fin_status;
   logic [skt_pkg::PAYLOAD_W-1:0]   fin_payload;
   logic [CNT_W+skt_pkg::COUNT_OUT_W-1:0] count_ext;

   assign req_ready = (state_ff == skt_pkg::FSM_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff >= CNT_W'(CAPACITY));

   // binary search probe
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = mid_sum[CNT_W:1];
   assign mid_idx    = mid[IDX_W-1:0];
   assign range_open = (lo_ff < hi_ff);
   assign step_lt    = range_open && lt_vec[mid_idx];
   assign step_gt    = range_open && !step_lt && gt_vec[mid_idx];

   // result of the current job, if it completes this cycle
   always_comb begin
      fin         = 1'b0;
      fin_status  = skt_pkg::STATUS_INSERTED;
      fin_payload = '0;
      case (state_ff)
         skt_pkg::FSM_INSERT: begin
            fin        = 1'b1;
            fin_status = full ? skt_pkg::STATUS_FULL : skt_pkg::STATUS_INSERTED;
         end
         skt_pkg::FSM_SEARCH: begin
            if (!range_open) begin
               fin        = 1'b1;
               fin_status = skt_pkg::STATUS_NOT_FOUND;
            end else if (!step_lt && !step_gt) begin
               fin         = 1'b1;
               fin_status  = skt_pkg::STATUS_FOUND;
               fin_payload = hit_payload;
            end
         end
         default: begin
            fin = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skt_pkg::FSM_IDLE: begin
            if (req_xfer) begin
               state_in = (req_operation == skt_pkg::OP_SEARCH) ?
                          skt_pkg::FSM_SEARCH : skt_pkg::FSM_INSERT;
            end
         end
         skt_pkg::FSM_INSERT, skt_pkg::FSM_SEARCH: begin
            if (fin) begin
               state_in = out_free ? skt_pkg::FSM_IDLE : skt_pkg::FSM_HOLD;
            end
         end
         skt_pkg::FSM_HOLD: begin
            if (out_free) begin
               state_in = skt_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = skt_pkg::FSM_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in        = count_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      job_op_in       = job_op_ff;
      job_key_in      = job_key_ff;
      job_payload_in  = job_payload_ff;
      hold_status_in  = hold_status_ff;
      hold_payload_in = hold_payload_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_payload_in  = rsp_payload_ff;
      rsp_count_in    = rsp_count_ff;
      cell_ctrl.ins_en  = 1'b0;
      cell_ctrl.key     = job_key_ff;
      cell_ctrl.payload = job_payload_ff;
      sel_en            = 1'b0;

      if (req_xfer) begin
         job_op_in      = req_operation;
         job_key_in     = req_key;
         job_payload_in = req_payload;
         lo_in          = '0;
         hi_in          = count_ff;
      end

      case (state_ff)
         skt_pkg::FSM_INSERT: begin
            if (!full) begin
               cell_ctrl.ins_en = 1'b1;
               count_in         = count_ff + 1'b1;
            end
         end
         skt_pkg::FSM_SEARCH: begin
            sel_en = 1'b1;
            if (step_lt) begin
               lo_in = mid + 1'b1;
            end else if (step_gt) begin
               hi_in = mid;
            end
         end
         default: begin
            sel_en = 1'b0;
         end
      endcase

      count_ext = {{skt_pkg::COUNT_OUT_W{1'b0}}, count_in};

      if (fin) begin
         if (out_free) begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = fin_status;
            rsp_payload_in = fin_payload;
            rsp_count_in   = count_ext[skt_pkg::COUNT_OUT_W-1:0];
         end else begin
            hold_status_in  = fin_status;
            hold_payload_in = fin_payload;
         end
      end else if (state_ff == skt_pkg::FSM_HOLD && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = hold_status_ff;
         rsp_payload_in = hold_payload_ff;
         rsp_count_in   = count_ext[skt_pkg::COUNT_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skt_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      job_op_ff       <= job_op_in;
      job_key_ff      <= job_key_in;
      job_payload_ff  <= job_payload_in;
      hold_status_ff  <= hold_status_in;
      hold_payload_ff <= hold_payload_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_payload_ff  <= rsp_payload_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_payload = rsp_payload_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign count             = count_ff;
   assign sel_idx           = mid_idx;

   // job type agrees with the state that runs it
   a_job_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::FSM_SEARCH) |-> (job_op_ff == skt_pkg::OP_SEARCH))
      else $error("search state entered for an insert job");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::FSM_SEARCH) |-> (hi_ff <= count_ff))
      else $error("search window beyond stored entries");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::FSM_INSERT && !full) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the table");

   a_hold_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::FSM_HOLD) |-> rsp_valid_ff)
      else $error("result held while output register empty");

endmodule

`default_nettype wire

FILE: src/sorted_key_table_insert_search_top.sv
// sorted key table with insert and binary search: top level
// depends on skt_pkg, skt_cell, skt_ctrl
//
// usage
//  - req channel: one transfer per item; req_operation selects insert or search,
//    req_key is the key, req_payload is stored on insert and ignored on search
//  - rsp channel: exactly one transfer per item, in item order; rsp_status,
//    rsp_found_payload (zero unless found) and rsp_entry_count after the item
//  - storage is a row of CAPACITY cells, each holding one key and payload;
//    an insert shifts every cell with a larger key one place up, all at once
//  - insert: accept step, then a shift step in which the item finishes
//  - search: accept step plus one probe per binary search step; the search
//    sequencer probes until the key is hit or the search window is empty
//  - one item is worked on at a time; req_ready is high while no item is in work
//  - results sit in an output register; a new item is taken while the last
//    result waits, and a finished result parks in a hold register if the
//    receiver still stalls, holding off further items until it drains
//  - reset (synchronous, active high) empties the table and drops any pending
//    result; cell contents are not cleared, entries above the count are never read
`default_nettype none

module sorted_key_table_insert_search_top #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic                              req_operation,
   input  wire logic [skt_pkg::KEY_W-1:0]         req_key,
   input  wire logic [skt_pkg::PAYLOAD_W-1:0]     req_payload,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [skt_pkg::STATUS_W-1:0]      rsp_status,
   output      logic [skt_pkg::PAYLOAD_W-1:0]     rsp_found_payload,
   output      logic [skt_pkg::COUNT_OUT_W-1:0]   rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   skt_pkg::cell_ctrl_type        cell_ctrl;
   logic [CNT_W-1:0]              count;
   logic                          sel_en;
   logic [IDX_W-1:0]              sel_idx;

   // per-cell signals; index 0 of the neighbor links is the tied-off left edge
   logic [CAPACITY-1:0]           lt_vec;
   logic [CAPACITY-1:0]           gt_vec;
   logic [CAPACITY-1:0]           valid_vec;
   logic [CAPACITY-1:0]           sel_vec;
   logic [skt_pkg::KEY_W-1:0]     key_arr     [CAPACITY];
   logic [skt_pkg::PAYLOAD_W-1:0] payload_arr [CAPACITY];
   logic [skt_pkg::PAYLOAD_W-1:0] sel_arr     [CAPACITY];
   logic [skt_pkg::PAYLOAD_W-1:0] hit_payload;

   skt_ctrl #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W),
      .IDX_W    (IDX_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_found_payload (rsp_found_payload),
      .rsp_entry_count   (rsp_entry_count),
      .lt_vec            (lt_vec),
      .gt_vec            (gt_vec),
      .hit_payload       (hit_payload),
      .cell_ctrl         (cell_ctrl),
      .count             (count),
      .sel_en            (sel_en),
      .sel_idx           (sel_idx)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      // cell holds a stored entry when it sits below the count
      assign valid_vec[i] = (count > CNT_W'(i));
      // probe select for the search readout
      assign sel_vec[i]   = sel_en && (sel_idx == IDX_W'(i));

      if (i == 0) begin : g_first
         skt_cell u_cell (
            .clock        (clock),
            .cell_ctrl    (cell_ctrl),
            .valid        (valid_vec[i]),
            .prev_gt      (1'b0),
            .prev_key     ('0),
            .prev_payload ('0),
            .sel          (sel_vec[i]),
            .key          (key_arr[i]),
            .payload      (payload_arr[i]),
            .gt           (gt_vec[i]),
            .lt           (lt_vec[i]),
            .sel_payload  (sel_arr[i])
         );
      end else begin : g_rest
         skt_cell u_cell (
            .clock        (clock),
            .cell_ctrl    (cell_ctrl),
            .valid        (valid_vec[i]),
            .prev_gt      (gt_vec[i-1]),
            .prev_key     (key_arr[i-1]),
            .prev_payload (payload_arr[i-1]),
            .sel          (sel_vec[i]),
            .key          (key_arr[i]),
            .payload      (payload_arr[i]),
            .gt           (gt_vec[i]),
            .lt           (lt_vec[i]),
            .sel_payload  (sel_arr[i])
         );
      end
   end

   // the selected cell drives its payload, all others drive zero
   always_comb begin
      hit_payload = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         hit_payload = hit_payload | sel_arr[j];
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// self-checking testbench for the sorted key table: directed, then random traffic
// holds a scoreboard class that mirrors the sorted table; depends on skt_pkg and the top level
`timescale 1ns / 100ps

localparam int TABLE_DEPTH = skt_pkg::CAPACITY_DEFAULT;

typedef struct packed {
   logic [skt_pkg::STATUS_W-1:0]    status;
   logic [skt_pkg::PAYLOAD_W-1:0]   payload;
   logic [skt_pkg::COUNT_OUT_W-1:0] entries;
} table_outcome_type;

class key_table_scoreboard;
   logic [skt_pkg::KEY_W-1:0]     stored_keys[TABLE_DEPTH];
   logic [skt_pkg::PAYLOAD_W-1:0] stored_payloads[TABLE_DEPTH];
   int unsigned                   fill;
   table_outcome_type             pending_results[$];
   int mismatches;
   int n_inserted, n_found, n_missing, n_refused;

   function new();
      fill = 0;
      mismatches = 0;
      n_inserted = 0;
      n_found = 0;
      n_missing = 0;
      n_refused = 0;
   endfunction

   // works out the result of one accepted item and updates the mirrored table
   function void note_request(logic op, logic [skt_pkg::KEY_W-1:0] key,
                              logic [skt_pkg::PAYLOAD_W-1:0] payload);
      table_outcome_type want;
      int pos, lo, hi, mid;
      bit hit;
      want = '0;
      if (op == skt_pkg::OP_INSERT) begin
         if (fill >= TABLE_DEPTH) begin
            want.status = skt_pkg::STATUS_FULL;
            n_refused++;
         end else begin
            pos = fill;
            while (pos > 0 && stored_keys[pos-1] > key) begin
               stored_keys[pos]     = stored_keys[pos-1];
               stored_payloads[pos] = stored_payloads[pos-1];
               pos--;
            end
            stored_keys[pos]     = key;
            stored_payloads[pos] = payload;
            fill++;
            want.status = skt_pkg::STATUS_INSERTED;
            n_inserted++;
         end
      end else begin
         lo = 0;
         hi = fill;
         hit = 1'b0;
         want.status = skt_pkg::STATUS_NOT_FOUND;
         while (lo < hi && !hit) begin
            mid = (lo + hi) / 2;
            if (stored_keys[mid] < key) begin
               lo = mid + 1;
            end else if (stored_keys[mid] > key) begin
               hi = mid;
            end else begin
               hit = 1'b1;
               want.status  = skt_pkg::STATUS_FOUND;
               want.payload = stored_payloads[mid];
            end
         end
         if (hit) n_found++;
         else n_missing++;
      end
      want.entries = skt_pkg::COUNT_OUT_W'(fill);
      pending_results.push_back(want);
   endfunction

   function void check_response(logic [skt_pkg::STATUS_W-1:0] status,
                                logic [skt_pkg::PAYLOAD_W-1:0] payload,
                                logic [skt_pkg::COUNT_OUT_W-1:0] entries);
      table_outcome_type want;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result with nothing outstanding: st %0d pl %h cnt %0d",
                     $realtime, status, payload, entries);
      end else begin
         want = pending_results.pop_front();
         if (status !== want.status || payload !== want.payload || entries !== want.entries) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch: exp st %0d pl %h cnt %0d, got st %0d pl %h cnt %0d",
                        $realtime, want.status, want.payload, want.entries,
                        status, payload, entries);
         end
      end
   endfunction
endclass

module tb;

   // clock, reset and block ports; every input starts at a known value
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_operation = skt_pkg::OP_INSERT;
   logic [skt_pkg::KEY_W-1:0]       req_key = '0;
   logic [skt_pkg::PAYLOAD_W-1:0]   req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [skt_pkg::STATUS_W-1:0]    rsp_status;
   logic [skt_pkg::PAYLOAD_W-1:0]   rsp_found_payload;
   logic [skt_pkg::COUNT_OUT_W-1:0] rsp_entry_count;

   // idle percentages for the sender and the receiver, changed per phase
   int send_idle_pct = 0;
   int stall_pct = 0;

   // random items sent so far and the random total, used to push the table to full late in the run
   int random_sent = 0;
   localparam int RANDOM_ITEMS = 850;

   key_table_scoreboard table_board = new();

   sorted_key_table_insert_search_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_found_payload (rsp_found_payload),
      .rsp_entry_count   (rsp_entry_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // run limit, far above the slowest correct run
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

   // receiver: check every result transfer, then draw the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         table_board.check_response(rsp_status, rsp_found_payload, rsp_entry_count);
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // one request transfer; valid stays high into the next item unless an idle gap is drawn
   task send_item(input logic op, input logic [skt_pkg::KEY_W-1:0] key,
                  input logic [skt_pkg::PAYLOAD_W-1:0] payload);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_payload   <= payload;
      do @(posedge clock); while (!req_ready);
      table_board.note_request(op, key, payload);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // random item: searches mostly hit stored keys or their neighbors, inserts lean on
   // a handful of small keys so that runs of equal keys build up
   task send_random_item;
      logic                      op;
      logic [skt_pkg::KEY_W-1:0] key;
      logic [63:0]               raw;
      int                        roll;
      int                        insert_pct;
      raw = {$urandom, $urandom};
      // late in the run, fill the table so that refused inserts get exercised
      insert_pct = (random_sent > RANDOM_ITEMS - 80 && table_board.fill < TABLE_DEPTH) ? 50 : 9;
      op = ($urandom_range(0, 99) < insert_pct) ? skt_pkg::OP_INSERT : skt_pkg::OP_SEARCH;
      roll = $urandom_range(0, 99);
      if (op == skt_pkg::OP_INSERT) begin
         if (roll < 35)
            key = skt_pkg::KEY_W'($urandom_range(0, 7));
         else if (roll < 45)
            key = $urandom_range(0, 1) ? '1 : '0;
         else
            key = skt_pkg::KEY_W'($urandom);
      end else begin
         if (table_board.fill > 0 && roll < 60)
            key = table_board.stored_keys[$urandom_range(0, table_board.fill - 1)];
         else if (table_board.fill > 0 && roll < 75)
            key = table_board.stored_keys[$urandom_range(0, table_board.fill - 1)]
                  + ($urandom_range(0, 1) ? skt_pkg::KEY_W'(1) : '1);
         else
            key = skt_pkg::KEY_W'($urandom);
      end
      send_item(op, key, raw[skt_pkg::PAYLOAD_W-1:0]);
      random_sent++;
   endtask

   task run_phase(input int items, input int idle_pct, input int stall);
      send_idle_pct = idle_pct;
      stall_pct = stall;
      repeat (items) send_random_item();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling
      // search in an empty table must miss
      send_item(skt_pkg::OP_SEARCH, '0, '0);
      // extreme keys and payloads
      send_item(skt_pkg::OP_INSERT, '1, '1);
      send_item(skt_pkg::OP_INSERT, '0, '0);
      // equal keys keep arrival order
      send_item(skt_pkg::OP_INSERT, '0, 48'h1);
      send_item(skt_pkg::OP_INSERT, 16'h8000, 48'haaaa_aaaa_aaaa);
      send_item(skt_pkg::OP_INSERT, 16'h00ff, 48'h5555_5555_5555);
      send_item(skt_pkg::OP_INSERT, 16'h8000, 48'h0123_4567_89ab);
      send_item(skt_pkg::OP_INSERT, 16'h7fff, 48'h8000_0000_0000);
      // searches that hit at both ends and in the middle, payload on search is ignored
      send_item(skt_pkg::OP_SEARCH, '0, '1);
      send_item(skt_pkg::OP_SEARCH, '1, '0);
      send_item(skt_pkg::OP_SEARCH, 16'h8000, 48'hdead_beef_cafe);
      send_item(skt_pkg::OP_SEARCH, 16'h00ff, '0);
      send_item(skt_pkg::OP_SEARCH, 16'h7fff, '0);
      // misses between stored keys
      send_item(skt_pkg::OP_SEARCH, 16'h1234, '0);
      send_item(skt_pkg::OP_SEARCH, 16'h8001, '0);
      send_item(skt_pkg::OP_SEARCH, 16'h0001, '0);
      send_item(skt_pkg::OP_SEARCH, 16'hfffe, '0);
      // insert of key zero after some traffic, placed behind the zero keys already stored
      send_item(skt_pkg::OP_INSERT, '0, 48'hffff_0000_ffff);
      send_item(skt_pkg::OP_SEARCH, '0, '0);

      // random part in four idling phases
      run_phase(212, 0, 0);
      run_phase(212, 79, 0);
      run_phase(212, 0, 79);
      run_phase(RANDOM_ITEMS - 636, 34, 34);

      // drain: drop valid, keep the receiver ready and wait for the outstanding results
      req_valid <= 1'b0;
      stall_pct = 0;
      while (table_board.pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("covered %0d inserts, %0d refused on a full table, %0d searches found, %0d missed",
               table_board.n_inserted, table_board.n_refused, table_board.n_found,
               table_board.n_missing);
      $display("final entry count %0d, mismatches %0d", table_board.fill, table_board.mismatches);
      if (table_board.mismatches == 0 && table_board.pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/skt_pkg.sv
src/skt_cell.sv
src/skt_ctrl.sv
src/sorted_key_table_insert_search_top.sv
tb/sv/tb.sv
